// File: design/plad_pkg.sv
// shared types and constants for the point light attenuation and direction unit
package plad_pkg;

    localparam int CfgIdxW = 3;
    localparam int RegW    = 32;
    localparam int MagW    = 33;
    localparam int SumW    = 66;
    localparam int RootW   = 33;
    localparam int RemW    = 36;
    localparam int DivW    = 49;
    localparam int QuotW   = 16;

    localparam logic [31:0] ONE_Q16   = 32'd65536;
    localparam logic [16:0] ATTEN_ONE = 17'd65536;
    localparam logic [15:0] DIR_PMAX  = 16'd32767;
    localparam logic [15:0] DIR_NMAX  = 16'd32768;

    typedef enum logic [CfgIdxW-1:0] {
        REG_LIGHT_X     = 3'd0,
        REG_LIGHT_Y     = 3'd1,
        REG_LIGHT_Z     = 3'd2,
        REG_COEF_CONST  = 3'd3,
        REG_COEF_LINEAR = 3'd4,
        REG_COEF_QUAD   = 3'd5
    } t_cfg_idx;

    typedef logic [2:0][MagW-1:0] t_mag3;
    typedef logic [2:0][DivW-1:0] t_rem3;
    typedef logic [2:0][QuotW-1:0] t_quot3;

endpackage

// File: design/point_light_attenuation_direction_unit.sv
// beats flow through the delta, square, sum, root, coefficient, divider and output stages
// one beat per cycle unless stalled: 33-step square root and 16-step dividers are fully staged
// the whole pipeline advances when the output register is empty or being taken
// reset (synchronous, active low) clears all valid bits and loads the register reset values
// light position 0, constant coefficient 1.0, linear and quadratic coefficients 0
module point_light_attenuation_direction_unit #(
    parameter int COORD_FRAC_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [95:0] s_tdata,   // point_x, point_y, point_z
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata    // atten[16:0], dir_x, dir_y, dir_z, zero_dist, zero pad
);

    localparam int NStg  = 56;
    localparam int NSqrt = 33;
    localparam int NDiv  = 16;
    localparam int FB    = COORD_FRAC_BITS;

    logic [31:0] r_light_x, r_light_y, r_light_z;
    logic [31:0] r_coef_c, r_coef_l, r_coef_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_light_x <= '0;
            r_light_y <= '0;
            r_light_z <= '0;
            r_coef_c  <= plad_pkg::ONE_Q16;
            r_coef_l  <= '0;
            r_coef_q  <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                plad_pkg::REG_LIGHT_X:     r_light_x <= i_cfg_data;
                plad_pkg::REG_LIGHT_Y:     r_light_y <= i_cfg_data;
                plad_pkg::REG_LIGHT_Z:     r_light_z <= i_cfg_data;
                plad_pkg::REG_COEF_CONST:  r_coef_c  <= i_cfg_data;
                plad_pkg::REG_COEF_LINEAR: r_coef_l  <= i_cfg_data;
                plad_pkg::REG_COEF_QUAD:   r_coef_q  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    logic            adv;
    logic [NStg-1:0] r_vld;

    assign adv      = !r_vld[NStg-1] || m_tready;
    assign s_tready = adv;
    assign m_tvalid = r_vld[NStg-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (adv) begin
            r_vld <= {r_vld[NStg-2:0], s_tvalid};
        end
    end

    // stage 1: deltas toward the light
    logic signed [32:0] dlt [3];
    logic [31:0]        lgt [3];
    plad_pkg::t_mag3    r1_mag;
    logic [2:0]         r1_neg;

    assign lgt[0] = r_light_x;
    assign lgt[1] = r_light_y;
    assign lgt[2] = r_light_z;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            dlt[i] = $signed({lgt[i][31], lgt[i]})
                   - $signed({s_tdata[32*i+31], s_tdata[32*i +: 32]});
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int i = 0; i < 3; i++) begin
                r1_neg[i] <= dlt[i][32];
                r1_mag[i] <= dlt[i][32] ? 33'(-dlt[i]) : 33'(dlt[i]);
            end
        end
    end

    // stage 2: squares
    logic [64:0]     r2_sq [3];
    plad_pkg::t_mag3 r2_mag;
    logic [2:0]      r2_neg;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int i = 0; i < 3; i++) begin
                r2_sq[i] <= 65'(r1_mag[i] * r1_mag[i]);
            end
            r2_mag <= r1_mag;
            r2_neg <= r1_neg;
        end
    end

    // stage 3: squared length
    logic [plad_pkg::SumW-1:0] r3_sum;
    plad_pkg::t_mag3           r3_mag;
    logic [2:0]                r3_neg;
    logic                      r3_zero;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r3_sum  <= {1'b0, r2_sq[0]} + {1'b0, r2_sq[1]} + {1'b0, r2_sq[2]};
            r3_zero <= (r2_sq[0] == '0) && (r2_sq[1] == '0) && (r2_sq[2] == '0);
            r3_mag  <= r2_mag;
            r3_neg  <= r2_neg;
        end
    end

    // square root, one result bit per stage
    logic [plad_pkg::RemW-1:0]  r_sr_rem  [1:NSqrt];
    logic [plad_pkg::RootW-1:0] r_sr_root [1:NSqrt];
    logic [plad_pkg::SumW-1:0]  r_sr_sum  [1:NSqrt];
    plad_pkg::t_mag3            r_sr_mag  [1:NSqrt];
    logic [2:0]                 r_sr_neg  [1:NSqrt];
    logic                       r_sr_zero [1:NSqrt];

    for (genvar k = 0; k < NSqrt; k++) begin : g_sqrt
        logic [plad_pkg::RemW-1:0]  rem_in, rem_sh, trial;
        logic [plad_pkg::RootW-1:0] root_in;
        logic [plad_pkg::SumW-1:0]  sum_in;
        plad_pkg::t_mag3            mag_in;
        logic [2:0]                 neg_in;
        logic                       zero_in;

        if (k == 0) begin : g_first
            assign rem_in  = '0;
            assign root_in = '0;
            assign sum_in  = r3_sum;
            assign mag_in  = r3_mag;
            assign neg_in  = r3_neg;
            assign zero_in = r3_zero;
        end else begin : g_next
            assign rem_in  = r_sr_rem[k];
            assign root_in = r_sr_root[k];
            assign sum_in  = r_sr_sum[k];
            assign mag_in  = r_sr_mag[k];
            assign neg_in  = r_sr_neg[k];
            assign zero_in = r_sr_zero[k];
        end

        assign rem_sh = {rem_in[plad_pkg::RemW-3:0], sum_in[2*(NSqrt-1-k) +: 2]};
        assign trial  = {1'b0, root_in, 2'b01};

        always_ff @(posedge i_clk) begin
            if (adv) begin
                if (rem_sh >= trial) begin
                    r_sr_rem[k+1]  <= rem_sh - trial;
                    r_sr_root[k+1] <= {root_in[plad_pkg::RootW-2:0], 1'b1};
                end else begin
                    r_sr_rem[k+1]  <= rem_sh;
                    r_sr_root[k+1] <= {root_in[plad_pkg::RootW-2:0], 1'b0};
                end
                r_sr_sum[k+1]  <= sum_in;
                r_sr_mag[k+1]  <= mag_in;
                r_sr_neg[k+1]  <= neg_in;
                r_sr_zero[k+1] <= zero_in;
            end
        end
    end

    // stage 37: partial products of the coefficient terms
    logic [64:0]     r4_plin;
    logic [63:0]     r4_q0, r4_q1;
    logic [33:0]     r4_q2;
    logic [32:0]     r4_d;
    plad_pkg::t_mag3 r4_mag;
    logic [2:0]      r4_neg;
    logic            r4_zero;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r4_plin <= 65'(r_coef_l * r_sr_root[NSqrt]);
            r4_q0   <= 64'(r_coef_q * r_sr_sum[NSqrt][31:0]);
            r4_q1   <= 64'(r_coef_q * r_sr_sum[NSqrt][63:32]);
            r4_q2   <= 34'(r_coef_q * r_sr_sum[NSqrt][65:64]);
            r4_d    <= r_sr_root[NSqrt];
            r4_mag  <= r_sr_mag[NSqrt];
            r4_neg  <= r_sr_neg[NSqrt];
            r4_zero <= r_sr_zero[NSqrt];
        end
    end

    // stage 38: scaled and saturated terms
    logic [97:0]     pquad, t2_full;
    logic [64:0]     t1_full;
    logic [31:0]     r5_t1, r5_t2;
    logic [32:0]     r5_d;
    plad_pkg::t_mag3 r5_mag;
    logic [2:0]      r5_neg;
    logic            r5_zero;

    assign pquad   = {r4_q2, 64'b0} + {2'b0, r4_q1, 32'b0} + {34'b0, r4_q0};
    assign t2_full = pquad >> (2 * FB);
    assign t1_full = r4_plin >> FB;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r5_t1   <= (|t1_full[64:32]) ? '1 : t1_full[31:0];
            r5_t2   <= (|t2_full[97:32]) ? '1 : t2_full[31:0];
            r5_d    <= r4_d;
            r5_mag  <= r4_mag;
            r5_neg  <= r4_neg;
            r5_zero <= r4_zero;
        end
    end

    // stage 39: denominator and divider operands
    logic [33:0]     den_sum;
    logic [31:0]     den_sat;
    logic [31:0]     r6_den;
    logic            r6_small;
    plad_pkg::t_rem3 r6_ndir;
    logic [32:0]     r6_d;
    logic [2:0]      r6_neg;
    logic            r6_zero;

    assign den_sum = {2'b0, r_coef_c} + {2'b0, r5_t1} + {2'b0, r5_t2};
    assign den_sat = (|den_sum[33:32]) ? '1 : den_sum[31:0];

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r6_den   <= den_sat;
            r6_small <= den_sat <= plad_pkg::ONE_Q16;
            for (int i = 0; i < 3; i++) begin
                r6_ndir[i] <= {r5_mag[i], 15'b0} + {16'b0, 1'b0, r5_d[32:1]};
            end
            r6_d    <= r5_d;
            r6_neg  <= r5_neg;
            r6_zero <= r5_zero;
        end
    end

    // dividers, one quotient bit per stage from the top
    logic [plad_pkg::DivW-1:0]  r_dv_arem [1:NDiv];
    logic [plad_pkg::QuotW-1:0] r_dv_aq   [1:NDiv];
    plad_pkg::t_rem3            r_dv_drem [1:NDiv];
    plad_pkg::t_quot3           r_dv_dq   [1:NDiv];
    logic [31:0]                r_dv_den  [1:NDiv];
    logic [32:0]                r_dv_d    [1:NDiv];
    logic                       r_dv_small[1:NDiv];
    logic [2:0]                 r_dv_neg  [1:NDiv];
    logic                       r_dv_zero [1:NDiv];

    for (genvar k = 0; k < NDiv; k++) begin : g_div
        localparam int Bit = NDiv - 1 - k;
        logic [plad_pkg::DivW-1:0]  arem_in, aden;
        logic [plad_pkg::QuotW-1:0] aq_in;
        plad_pkg::t_rem3            drem_in;
        plad_pkg::t_quot3           dq_in;
        logic [plad_pkg::DivW-1:0]  ddiv;
        logic [31:0]                den_in;
        logic [32:0]                d_in;
        logic                       small_in, zero_in;
        logic [2:0]                 neg_in;

        if (k == 0) begin : g_first
            assign arem_in  = plad_pkg::DivW'(64'h1_0000_0000);
            assign aq_in    = '0;
            assign drem_in  = r6_ndir;
            assign dq_in    = '0;
            assign den_in   = r6_den;
            assign d_in     = r6_d;
            assign small_in = r6_small;
            assign neg_in   = r6_neg;
            assign zero_in  = r6_zero;
        end else begin : g_next
            assign arem_in  = r_dv_arem[k];
            assign aq_in    = r_dv_aq[k];
            assign drem_in  = r_dv_drem[k];
            assign dq_in    = r_dv_dq[k];
            assign den_in   = r_dv_den[k];
            assign d_in     = r_dv_d[k];
            assign small_in = r_dv_small[k];
            assign neg_in   = r_dv_neg[k];
            assign zero_in  = r_dv_zero[k];
        end

        assign aden = {17'b0, den_in} << Bit;
        assign ddiv = {16'b0, d_in} << Bit;

        always_ff @(posedge i_clk) begin
            if (adv) begin
                if (arem_in >= aden) begin
                    r_dv_arem[k+1] <= arem_in - aden;
                    r_dv_aq[k+1]   <= aq_in | (plad_pkg::QuotW'(1) << Bit);
                end else begin
                    r_dv_arem[k+1] <= arem_in;
                    r_dv_aq[k+1]   <= aq_in;
                end
                for (int i = 0; i < 3; i++) begin
                    if (drem_in[i] >= ddiv) begin
                        r_dv_drem[k+1][i] <= drem_in[i] - ddiv;
                        r_dv_dq[k+1][i]   <= dq_in[i] | (plad_pkg::QuotW'(1) << Bit);
                    end else begin
                        r_dv_drem[k+1][i] <= drem_in[i];
                        r_dv_dq[k+1][i]   <= dq_in[i];
                    end
                end
                r_dv_den[k+1]   <= den_in;
                r_dv_d[k+1]     <= d_in;
                r_dv_small[k+1] <= small_in;
                r_dv_neg[k+1]   <= neg_in;
                r_dv_zero[k+1]  <= zero_in;
            end
        end
    end

    // output register
    logic [16:0] r_atten;
    logic [15:0] r_dir [3];
    logic        r_zero;
    logic [15:0] dir_q, dir_val [3];

    always_comb begin
        dir_q = '0;
        for (int i = 0; i < 3; i++) begin
            dir_q = r_dv_dq[NDiv][i];
            if (r_dv_zero[NDiv]) begin
                dir_val[i] = '0;
            end else if (r_dv_neg[NDiv][i]) begin
                dir_val[i] = 16'(-((dir_q > plad_pkg::DIR_NMAX) ? plad_pkg::DIR_NMAX : dir_q));
            end else begin
                dir_val[i] = (dir_q > plad_pkg::DIR_PMAX) ? plad_pkg::DIR_PMAX : dir_q;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_atten <= r_dv_small[NDiv] ? plad_pkg::ATTEN_ONE : {1'b0, r_dv_aq[NDiv]};
            for (int i = 0; i < 3; i++) begin
                r_dir[i] <= dir_val[i];
            end
            r_zero <= r_dv_zero[NDiv];
        end
    end

    assign m_tdata = {6'b0, r_zero, r_dir[2], r_dir[1], r_dir[0], r_atten};

    // the last remainders and the last divider copies of the operands are unused and simply dropped
    logic unused_ok;
    assign unused_ok = ^{r_dv_arem[NDiv], r_dv_drem[NDiv], r_dv_den[NDiv], r_dv_d[NDiv],
                         r_sr_rem[NSqrt]};

    a_zero_dir: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && r_zero |-> (r_dir[0] == '0) && (r_dir[1] == '0) && (r_dir[2] == '0))
        else $error("zero distance with nonzero direction");

    a_atten_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid |-> (r_atten != '0) && (r_atten <= plad_pkg::ATTEN_ONE))
        else $error("attenuation out of range");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_tready |=> $stable(r_vld))
        else $error("pipeline moved while stalled");

    a_small_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv && r_vld[NStg-2] && r_dv_small[NDiv] |=> r_atten == plad_pkg::ATTEN_ONE)
        else $error("small denominator did not give full attenuation");

endmodule

// File: verif/testbench.sv
// testbench for the point light attenuation and direction unit
`timescale 1ns / 1ps

module testbench;

    typedef struct packed {
        logic        zero_dist;
        logic [15:0] dir_z;
        logic [15:0] dir_y;
        logic [15:0] dir_x;
        logic [16:0] atten;
    } t_light_res;

    typedef struct {
        logic [31:0] px, py, pz;
        bit          known;
        t_light_res  res;
    } t_row;

    localparam int FracBits  = 16;
    localparam int Latency   = 56;
    localparam int CycleCap  = 400000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [2:0]  i_cfg_idx = '0;
    logic [31:0] i_cfg_data = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [95:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [71:0] m_tdata;

    point_light_attenuation_direction_unit dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    logic signed [31:0] lx, ly, lz;
    logic [31:0] kc, kl, kq;
    t_light_res expected_beats[$];
    int errors = 0;
    int cycles = 0;
    int send_idle = 0, recv_idle = 0;

    function automatic logic [15:0] dir_comp(logic signed [32:0] delta, logic [32:0] dlen);
        logic [32:0] mag;
        logic [63:0] q;
        mag = delta < 0 ? -delta : delta;
        q = ({31'd0, mag} << 15) + dlen / 2;
        q = q / dlen;
        if (delta < 0) begin
            if (q > 32768) q = 32768;
            return -q[15:0];
        end
        if (q > 32767) q = 32767;
        return q[15:0];
    endfunction

    function automatic t_light_res light_predict(logic [31:0] px, logic [31:0] py,
                                                 logic [31:0] pz);
        logic signed [32:0] dx, dy, dz;
        logic [65:0] ssum;
        logic [32:0] dlen;
        logic [33:0] trial;
        logic [131:0] prod;
        logic [35:0] den;
        logic [63:0] t1, t2;
        t_light_res r;
        dx = $signed({lx[31], lx}) - $signed({px[31], px});
        dy = $signed({ly[31], ly}) - $signed({py[31], py});
        dz = $signed({lz[31], lz}) - $signed({pz[31], pz});
        ssum = 66'(dx * dx) + 66'(dy * dy) + 66'(dz * dz);
        dlen = 0;
        for (int b = 32; b >= 0; b--) begin
            trial = dlen | (34'd1 << b);
            if (68'(trial) * 68'(trial) <= 68'(ssum)) dlen = trial[32:0];
        end
        prod = 132'(kl) * 132'(dlen);
        prod = prod >> FracBits;
        t1 = prod > 132'hFFFFFFFF ? 64'hFFFFFFFF : prod[63:0];
        prod = 132'(kq) * 132'(ssum);
        prod = prod >> (2 * FracBits);
        t2 = prod > 132'hFFFFFFFF ? 64'hFFFFFFFF : prod[63:0];
        den = 36'(kc) + 36'(t1) + 36'(t2);
        if (den > 36'hFFFFFFFF) den = 36'hFFFFFFFF;
        r.atten = den <= 36'(plad_pkg::ONE_Q16) ? plad_pkg::ATTEN_ONE :
                  17'((64'd1 << 32) / den);
        if (ssum == 0) begin
            r.dir_x = 0; r.dir_y = 0; r.dir_z = 0; r.zero_dist = 1'b1;
        end else begin
            r.dir_x = dir_comp(dx, dlen);
            r.dir_y = dir_comp(dy, dlen);
            r.dir_z = dir_comp(dz, dlen);
            r.zero_dist = 1'b0;
        end
        return r;
    endfunction

    task automatic write_reg(plad_pkg::t_cfg_idx idx, logic [31:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        case (idx)
            plad_pkg::REG_LIGHT_X:     lx = val;
            plad_pkg::REG_LIGHT_Y:     ly = val;
            plad_pkg::REG_LIGHT_Z:     lz = val;
            plad_pkg::REG_COEF_CONST:  kc = val;
            plad_pkg::REG_COEF_LINEAR: kl = val;
            plad_pkg::REG_COEF_QUAD:   kq = val;
            default: ;
        endcase
    endtask

    // one point beat; expectation queued when accepted
    task automatic send_point(logic [31:0] px, logic [31:0] py, logic [31:0] pz,
                              bit known, t_light_res res);
        while ($urandom_range(99) < send_idle) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {pz, py, px};
        do @(posedge i_clk); while (!s_tready);
        expected_beats.push_back(known ? res : light_predict(px, py, pz));
    endtask

    task automatic drain;
        s_tvalid <= 1'b0;
        while (expected_beats.size() != 0) @(posedge i_clk);
        repeat (Latency + 8) @(posedge i_clk);
    endtask

    function automatic logic [31:0] rand_coord(int mode);
        case (mode)
            0: return $urandom();
            1: return $urandom_range(1, 0) ? 32'h7FFFFFFF : 32'h80000000;
            2: return 32'($signed($urandom_range(2000000)) - 1000000);
            default: return 32'($signed($urandom_range(64)) - 32);
        endcase
    endfunction

    always @(posedge i_clk) begin
        m_tready <= ($urandom_range(99) >= recv_idle);
        cycles <= cycles + 1;
        if (cycles > CycleCap) begin
            $display("== FAIL ==");
            $finish;
        end
        if (i_rst_n && m_tvalid && m_tready) begin
            if (expected_beats.size() == 0) begin
                $display("%0t unexpected beat actual %h", $time, m_tdata[65:0]);
                errors++;
            end else begin
                t_light_res e, a;
                e = expected_beats.pop_front();
                a = m_tdata[65:0];
                if (a.atten !== e.atten || a.dir_x !== e.dir_x || a.dir_y !== e.dir_y ||
                    a.dir_z !== e.dir_z || a.zero_dist !== e.zero_dist) begin
                    $display("%0t mismatch expected %h actual %h", $time, e, a);
                    errors++;
                end
            end
        end
    end

    t_row plan[] = '{
        '{32'h0, 32'h0, 32'h0, 1, '{1'b1, 16'd0, 16'd0, 16'd0, plad_pkg::ATTEN_ONE}},
        '{32'h10000, 32'h0, 32'h0, 1,
          '{1'b0, 16'd0, 16'd0, 16'h8000, plad_pkg::ATTEN_ONE}},
        '{32'hFFFF0000, 32'h0, 32'h0, 1,
          '{1'b0, 16'd0, 16'd0, plad_pkg::DIR_PMAX, plad_pkg::ATTEN_ONE}},
        '{32'h0, 32'h80000000, 32'h0, 1,
          '{1'b0, 16'd0, plad_pkg::DIR_PMAX, 16'd0, plad_pkg::ATTEN_ONE}},
        '{32'h0, 32'h0, 32'h7FFFFFFF, 1,
          '{1'b0, 16'h8000, 16'd0, 16'd0, plad_pkg::ATTEN_ONE}},
        '{32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 0, '0},
        '{32'h80000000, 32'h80000000, 32'h80000000, 0, '0},
        '{32'h10000, 32'h10000, 32'h0, 0, '0},
        '{32'h1, 32'hFFFFFFFF, 32'h1, 0, '0}
    };

    initial begin
        t_light_res none;
        int mode;
        logic [31:0] cfg_set[6];
        none = '0;
        lx = 0; ly = 0; lz = 0; kc = plad_pkg::ONE_Q16; kl = 0; kq = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        foreach (plan[i]) send_point(plan[i].px, plan[i].py, plan[i].pz, plan[i].known,
                                     plan[i].res);
        drain();
        // attenuation extremes at the light itself
        write_reg(plad_pkg::REG_COEF_CONST, 32'hFFFFFFFF);
        send_point(0, 0, 0, 1, '{1'b1, 16'd0, 16'd0, 16'd0, 17'd1});
        drain();
        write_reg(plad_pkg::REG_COEF_CONST, 32'd0);
        send_point(0, 0, 0, 1, '{1'b1, 16'd0, 16'd0, 16'd0, plad_pkg::ATTEN_ONE});
        drain();
        write_reg(plad_pkg::REG_COEF_CONST, plad_pkg::ONE_Q16);
        write_reg(plad_pkg::REG_COEF_LINEAR, 32'hFFFFFFFF);
        write_reg(plad_pkg::REG_COEF_QUAD, 32'hFFFFFFFF);
        foreach (plan[i]) send_point(plan[i].px, plan[i].py, plan[i].pz, 0, none);
        drain();
        for (int ph = 0; ph < 9; ph++) begin
            send_idle = ph < 3 ? 27 : (ph < 6 ? 84 : 0);
            recv_idle = ph < 3 ? 84 : (ph < 6 ? 27 : 0);
            if (ph % 3 == 0) begin
                cfg_set[0] = rand_coord(ph % 4);
                cfg_set[1] = rand_coord((ph + 1) % 4);
                cfg_set[2] = rand_coord(ph == 3 ? 1 : 2);
            end else begin
                cfg_set[0] = rand_coord(3); cfg_set[1] = rand_coord(3);
                cfg_set[2] = rand_coord(3);
            end
            cfg_set[3] = ph == 8 ? 32'd0 : $urandom_range(ph, 0) == 0 ? plad_pkg::ONE_Q16 :
                         $urandom();
            cfg_set[4] = ph == 4 ? 32'hFFFFFFFF : $urandom_range(1, 0) ? $urandom() :
                         $urandom_range(4096);
            cfg_set[5] = ph == 5 ? 32'hFFFFFFFF : $urandom_range(1, 0) ? $urandom() :
                         $urandom_range(256);
            for (int r = 0; r < 6; r++) write_reg(plad_pkg::t_cfg_idx'(r), cfg_set[r]);
            for (int n = 0; n < 190; n++) begin
                mode = $urandom_range(3);
                if ($urandom_range(19) == 0)
                    send_point(lx, ly, lz, 0, none);
                else
                    send_point(rand_coord(mode), rand_coord(mode), rand_coord(mode), 0, none);
            end
            drain();
        end
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule

// File: filelist.f
design/plad_pkg.sv
design/point_light_attenuation_direction_unit.sv
verif/testbench.sv
